[hw/rtl/kmsa_pkg.sv]
// ----------------------------------------------------------------------------
// kmsa_pkg
// Shared types and codes for the keyed matrix store: request kinds, result
// codes, the command word passed from front end to back end, FSM states.
// ----------------------------------------------------------------------------
package kmsa_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int MAX_DIM_DEF = 8;
    localparam int QDEPTH      = 4;
    localparam int QAW         = 2;

    // request kinds
    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_ADD    = 3'd2;
    localparam logic [2:0] KIND_SUB    = 3'd3;
    localparam logic [2:0] KIND_SCALE  = 3'd4;
    localparam logic [2:0] KIND_MUL    = 3'd5;

    // result codes
    localparam logic [2:0] CODE_ELEM    = 3'd0;
    localparam logic [2:0] CODE_EMPTY   = 3'd1;
    localparam logic [2:0] CODE_STORED  = 3'd2;
    localparam logic [2:0] CODE_REFUSED = 3'd3;
    localparam logic [2:0] CODE_WRITTEN = 3'd4;
    localparam logic [2:0] CODE_IGNORED = 3'd5;

    typedef enum logic [2:0] {
        OP_STATUS, OP_CLEAR, OP_WRITE, OP_ADD, OP_SUB, OP_SCALE, OP_MUL
    } op_t;

    // slot fields sized for the largest store (64 slots)
    typedef struct packed {
        op_t         op;
        logic [2:0]  code;
        logic [5:0]  sa;
        logic [5:0]  sb;
        logic [3:0]  nrows;
        logic [3:0]  ncols;
        logic [3:0]  inner;
        logic [2:0]  r;
        logic [2:0]  c;
        logic [31:0] data;
    } cmd_t;

    typedef enum logic [1:0] {F_IDLE, F_SCAN, F_DECIDE} fs_t;

    typedef enum logic [2:0] {
        B_IDLE, B_WRITE, B_CLEAR, B_STAT, B_RD, B_MUL, B_ACC, B_EMIT
    } bs_t;

endpackage

[hw/rtl/keyed_matrix_store_arithmetic.sv]
// ----------------------------------------------------------------------------
// keyed_matrix_store_arithmetic
// Keyed store of up to SLOTS matrices (Q16.16) with add, subtract, scale and
// multiply; results stream out row-major, last marked.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | carries
//  ---------+-----------+--------------------+--------------------------------
//  s_*      | in        | s_valid / s_ready  | one request (create/write/op)
//  m_*      | out       | m_valid / m_ready  | result element or status
//
//  Front end: accept, slot scan, decide; the next request is taken once the
//  last one is queued. Back end: create clears the slot (sweep of MAX_DIM^2
//  elements); operations run the single element-memory read / multiply /
//  accumulate loop inner times per element, inner = 1 except for multiply.
//  Reset (aresetn, synchronous) empties the slot table and the queue.
//  A four-deep command queue lets the front end run ahead of a stalled m_.
// ----------------------------------------------------------------------------
module keyed_matrix_store_arithmetic import kmsa_pkg::*; #(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_kind,
    input  logic [7:0]         s_first_key,
    input  logic [7:0]         s_second_key,
    input  logic [3:0]         s_rows,
    input  logic [3:0]         s_cols,
    input  logic [2:0]         s_row,
    input  logic [2:0]         s_col,
    input  logic signed [31:0] s_value,
    input  logic signed [31:0] s_factor,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_code,
    output logic [2:0]         m_out_row,
    output logic [2:0]         m_out_col,
    output logic signed [31:0] m_out_value,
    output logic [3:0]         m_rows_out,
    output logic [3:0]         m_cols_out,
    output logic               m_last
);

    // front -> queue -> back
    cmd_t push_cmd, pop_cmd;
    logic push, full, pop, q_valid;

    kmsa_front #(.SLOTS(SLOTS), .MAX_DIM(MAX_DIM)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_first_key  (s_first_key),
        .s_second_key (s_second_key),
        .s_rows       (s_rows),
        .s_cols       (s_cols),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_value      (s_value),
        .s_factor     (s_factor),
        .q_push       (push),
        .q_cmd        (push_cmd),
        .q_full       (full)
    );

    kmsa_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .full    (full),
        .pop     (pop),
        .dout    (pop_cmd),
        .valid   (q_valid)
    );

    kmsa_back #(.SLOTS(SLOTS), .MAX_DIM(MAX_DIM)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (pop_cmd),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code      (m_code),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_out_value (m_out_value),
        .m_rows_out  (m_rows_out),
        .m_cols_out  (m_cols_out),
        .m_last      (m_last)
    );

endmodule

[hw/rtl/kmsa_front.sv]
// ----------------------------------------------------------------------------
// kmsa_front
// Takes requests, scans the slot table and turns each request into one
// command for the back end. Owns slot keys, sizes and valid bits.
// ----------------------------------------------------------------------------
module kmsa_front import kmsa_pkg::*; #(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_kind,
    input  logic [7:0]         s_first_key,
    input  logic [7:0]         s_second_key,
    input  logic [3:0]         s_rows,
    input  logic [3:0]         s_cols,
    input  logic [2:0]         s_row,
    input  logic [2:0]         s_col,
    input  logic signed [31:0] s_value,
    input  logic signed [31:0] s_factor,
    output logic               q_push,
    output cmd_t               q_cmd,
    input  logic               q_full
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    fs_t state_reg, state_next;

    logic [2:0]  kind_reg;
    logic [7:0]  k1_reg, k2_reg;
    logic [3:0]  rows_reg, cols_reg;
    logic [2:0]  row_reg, col_reg;
    logic [31:0] value_reg, factor_reg;

    logic [CW-1:0] scan_cnt_reg;
    logic          q_vld_reg;
    logic [SW-1:0] q_idx_reg;
    logic [7:0]    key_q_reg;
    logic [3:0]    rows_q_reg, cols_q_reg;

    logic          hit_a_reg, hit_b_reg, free_found_reg;
    logic [SW-1:0] slot_a_reg, slot_b_reg, free_slot_reg;
    logic [3:0]    rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [1:0]    nvalid_reg;

    logic [SLOTS-1:0] slot_valid_reg;
    logic             load_active_reg;
    logic [SW-1:0]    load_slot_reg;
    logic [3:0]       load_rows_reg, load_cols_reg;

    logic [7:0] key_mem  [SLOTS];
    logic [3:0] rows_mem [SLOTS];
    logic [3:0] cols_mem [SLOTS];

    logic [SW-1:0] rd_idx;
    logic          accept;
    logic          create_ok;
    logic          dims_ok;
    cmd_t          cmd;

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;
    assign rd_idx  = scan_cnt_reg[SW-1:0];
    assign q_push  = (state_reg == F_DECIDE) && !q_full;
    assign q_cmd   = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:   if (accept) state_next = F_SCAN;
            F_SCAN:   if (scan_cnt_reg == CW'(SLOTS)) state_next = F_DECIDE;
            F_DECIDE: if (q_push) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    // request capture and slot scan
    always_ff @(posedge aclk) begin
        key_q_reg  <= key_mem[rd_idx];
        rows_q_reg <= rows_mem[rd_idx];
        cols_q_reg <= cols_mem[rd_idx];
        q_idx_reg  <= rd_idx;
        if (accept) begin
            kind_reg       <= s_kind;
            k1_reg         <= s_first_key;
            k2_reg         <= s_second_key;
            rows_reg       <= s_rows;
            cols_reg       <= s_cols;
            row_reg        <= s_row;
            col_reg        <= s_col;
            value_reg      <= s_value;
            factor_reg     <= s_factor;
            scan_cnt_reg   <= '0;
            hit_a_reg      <= 1'b0;
            hit_b_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            nvalid_reg     <= 2'd0;
        end else if (state_reg == F_SCAN) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
        if (q_vld_reg) begin
            if (slot_valid_reg[q_idx_reg]) begin
                if (nvalid_reg != 2'd2) nvalid_reg <= nvalid_reg + 2'd1;
                if (!hit_a_reg && key_q_reg == k1_reg) begin
                    hit_a_reg  <= 1'b1;
                    slot_a_reg <= q_idx_reg;
                    rows_a_reg <= rows_q_reg;
                    cols_a_reg <= cols_q_reg;
                end
                if (!hit_b_reg && key_q_reg == k2_reg) begin
                    hit_b_reg  <= 1'b1;
                    slot_b_reg <= q_idx_reg;
                    rows_b_reg <= rows_q_reg;
                    cols_b_reg <= cols_q_reg;
                end
            end else if (!free_found_reg) begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= q_idx_reg;
            end
        end
    end

    // slot table update on an accepted create
    always_ff @(posedge aclk) begin
        if (q_push && create_ok) begin
            key_mem[free_slot_reg]  <= k1_reg;
            rows_mem[free_slot_reg] <= rows_reg;
            cols_mem[free_slot_reg] <= cols_reg;
            load_rows_reg           <= rows_reg;
            load_cols_reg           <= cols_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg       <= 1'b0;
            slot_valid_reg  <= '0;
            load_active_reg <= 1'b0;
            load_slot_reg   <= '0;
        end else begin
            q_vld_reg <= (state_reg == F_SCAN) && (scan_cnt_reg < CW'(SLOTS));
            if (q_push && create_ok) begin
                slot_valid_reg[free_slot_reg] <= 1'b1;
                load_active_reg               <= 1'b1;
                load_slot_reg                 <= free_slot_reg;
            end
        end
    end

    // classify
    always_comb begin
        cmd       = '0;
        cmd.op    = OP_STATUS;
        cmd.code  = CODE_IGNORED;
        create_ok = 1'b0;
        dims_ok   = (rows_reg inside {[1:MAX_DIM]}) && (cols_reg inside {[1:MAX_DIM]});
        case (kind_reg)
            KIND_CREATE: begin
                if (!dims_ok || hit_a_reg || !free_found_reg) begin
                    cmd.code = CODE_REFUSED;
                end else begin
                    create_ok = 1'b1;
                    cmd.op    = OP_CLEAR;
                    cmd.code  = CODE_STORED;
                    cmd.sa    = 6'(free_slot_reg);
                end
            end
            KIND_WRITE: begin
                if (load_active_reg && {1'b0, row_reg} < load_rows_reg
                        && {1'b0, col_reg} < load_cols_reg) begin
                    cmd.op   = OP_WRITE;
                    cmd.code = CODE_WRITTEN;
                    cmd.sa   = 6'(load_slot_reg);
                    cmd.r    = row_reg;
                    cmd.c    = col_reg;
                    cmd.data = value_reg;
                end
            end
            KIND_ADD, KIND_SUB: begin
                cmd.code = CODE_EMPTY;
                if (hit_a_reg && hit_b_reg && nvalid_reg == 2'd2
                        && rows_a_reg == rows_b_reg && cols_a_reg == cols_b_reg) begin
                    cmd.op    = (kind_reg == KIND_ADD) ? OP_ADD : OP_SUB;
                    cmd.code  = CODE_ELEM;
                    cmd.sa    = 6'(slot_a_reg);
                    cmd.sb    = 6'(slot_b_reg);
                    cmd.nrows = rows_a_reg;
                    cmd.ncols = cols_a_reg;
                    cmd.inner = 4'd1;
                end
            end
            KIND_SCALE: begin
                cmd.code = CODE_EMPTY;
                if (hit_a_reg) begin
                    cmd.op    = OP_SCALE;
                    cmd.code  = CODE_ELEM;
                    cmd.sa    = 6'(slot_a_reg);
                    cmd.nrows = rows_a_reg;
                    cmd.ncols = cols_a_reg;
                    cmd.inner = 4'd1;
                    cmd.data  = factor_reg;
                end
            end
            KIND_MUL: begin
                cmd.code = CODE_EMPTY;
                if (hit_a_reg && hit_b_reg && nvalid_reg == 2'd2
                        && cols_a_reg == rows_b_reg) begin
                    cmd.op    = OP_MUL;
                    cmd.code  = CODE_ELEM;
                    cmd.sa    = 6'(slot_a_reg);
                    cmd.sb    = 6'(slot_b_reg);
                    cmd.nrows = rows_a_reg;
                    cmd.ncols = cols_b_reg;
                    cmd.inner = cols_a_reg;
                end
            end
            default: begin
                cmd.code = CODE_IGNORED;
            end
        endcase
    end

endmodule

[hw/rtl/kmsa_queue.sv]
// ----------------------------------------------------------------------------
// kmsa_queue
// Small command FIFO between front end and back end.
// ----------------------------------------------------------------------------
module kmsa_queue import kmsa_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic valid
);

    cmd_t           fifo_mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign full  = (count_reg == (QAW + 1)'(QDEPTH));
    assign valid = (count_reg != '0);
    assign dout  = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) fifo_mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hw/rtl/kmsa_back.sv]
// ----------------------------------------------------------------------------
// kmsa_back
// Executes commands: element memory, clear sweep, element writes and the
// add / subtract / scale / multiply-accumulate sequencer with result register.
// ----------------------------------------------------------------------------
module kmsa_back import kmsa_pkg::*; #(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_code,
    output logic [2:0]         m_out_row,
    output logic [2:0]         m_out_col,
    output logic signed [31:0] m_out_value,
    output logic [3:0]         m_rows_out,
    output logic [3:0]         m_cols_out,
    output logic               m_last
);

    localparam int SW    = $clog2(SLOTS);
    localparam int DW    = $clog2(MAX_DIM);
    localparam int AW    = SW + 2 * DW;
    localparam int DEPTH = 1 << AW;

    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    bs_t state_reg, state_next;
    cmd_t cmd_reg;
    logic [DW-1:0] y_reg, x_reg, t_reg;

    logic [31:0] elem_mem [DEPTH];
    logic signed [31:0] rd_a_reg, rd_b_reg;
    logic signed [32:0] sum_reg;
    logic signed [63:0] prod_reg;
    logic signed [35:0] acc_reg;

    logic               m_valid_reg;
    logic [2:0]         code_reg, row_reg, col_reg;
    logic signed [31:0] value_reg;
    logic [3:0]         rows_out_reg, cols_out_reg;
    logic               last_reg;

    logic [SW-1:0] sa, sb;
    logic [AW-1:0] raddr_a, raddr_b, waddr;
    logic          we;
    logic [31:0]   wdata;
    logic signed [31:0] opb;
    logic signed [32:0] sum_w;
    logic signed [63:0] prod_w, rnd_w;
    logic signed [31:0] term_w, res_w;
    logic          out_free, load;
    logic          t_last, x_last, y_last, xc_last, yc_last;

    assign sa = cmd_reg.sa[SW-1:0];
    assign sb = cmd_reg.sb[SW-1:0];

    assign raddr_a = (cmd_reg.op == OP_MUL) ? {sa, y_reg, t_reg} : {sa, y_reg, x_reg};
    assign raddr_b = (cmd_reg.op == OP_MUL) ? {sb, t_reg, x_reg} : {sb, y_reg, x_reg};
    assign we      = (state_reg == B_WRITE) || (state_reg == B_CLEAR);
    assign waddr   = (state_reg == B_WRITE) ? {sa, cmd_reg.r[DW-1:0], cmd_reg.c[DW-1:0]}
                                            : {sa, y_reg, x_reg};
    assign wdata   = (state_reg == B_WRITE) ? cmd_reg.data : 32'd0;

    always_ff @(posedge aclk) begin
        if (we) elem_mem[waddr] <= wdata;
        rd_a_reg <= elem_mem[raddr_a];
        rd_b_reg <= elem_mem[raddr_b];
    end

    // arithmetic
    assign opb    = (cmd_reg.op == OP_SCALE) ? signed'(cmd_reg.data) : rd_b_reg;
    assign prod_w = rd_a_reg * opb;
    assign sum_w  = (cmd_reg.op == OP_SUB)
                  ? ({rd_a_reg[31], rd_a_reg} - {rd_b_reg[31], rd_b_reg})
                  : ({rd_a_reg[31], rd_a_reg} + {rd_b_reg[31], rd_b_reg});
    assign rnd_w  = (prod_reg + 64'sd32768) >>> 16;

    always_comb begin
        if (cmd_reg.op == OP_ADD || cmd_reg.op == OP_SUB) begin
            if (sum_reg[32] != sum_reg[31]) term_w = sum_reg[32] ? SMIN : SMAX;
            else                            term_w = sum_reg[31:0];
        end else begin
            if (rnd_w > 64'sh7FFF_FFFF)        term_w = SMAX;
            else if (rnd_w < -64'sh8000_0000)  term_w = SMIN;
            else                               term_w = rnd_w[31:0];
        end
        if (acc_reg > 36'sh0_7FFF_FFFF)       res_w = SMAX;
        else if (acc_reg < -36'sh8000_0000)   res_w = SMIN;
        else                                  res_w = acc_reg[31:0];
    end

    assign t_last  = (4'(t_reg) == cmd_reg.inner - 4'd1);
    assign x_last  = (4'(x_reg) == cmd_reg.ncols - 4'd1);
    assign y_last  = (4'(y_reg) == cmd_reg.nrows - 4'd1);
    assign xc_last = (x_reg == DW'(MAX_DIM - 1));
    assign yc_last = (y_reg == DW'(MAX_DIM - 1));

    assign out_free = !m_valid_reg || m_ready;
    assign load     = ((state_reg == B_STAT) || (state_reg == B_EMIT)) && out_free;
    assign q_pop    = (state_reg == B_IDLE) && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.op)
                        OP_STATUS: state_next = B_STAT;
                        OP_WRITE:  state_next = B_WRITE;
                        OP_CLEAR:  state_next = B_CLEAR;
                        default:   state_next = B_RD;
                    endcase
                end
            end
            B_WRITE: state_next = B_STAT;
            B_CLEAR: if (xc_last && yc_last) state_next = B_STAT;
            B_STAT:  if (out_free) state_next = B_IDLE;
            B_RD:    state_next = B_MUL;
            B_MUL:   state_next = B_ACC;
            B_ACC:   state_next = t_last ? B_EMIT : B_RD;
            B_EMIT:  if (out_free) state_next = (x_last && y_last) ? B_IDLE : B_RD;
            default: state_next = B_IDLE;
        endcase
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    cmd_reg <= q_cmd;
                    y_reg   <= '0;
                    x_reg   <= '0;
                    t_reg   <= '0;
                    acc_reg <= '0;
                end
            end
            B_CLEAR: begin
                x_reg <= xc_last ? '0 : x_reg + 1'b1;
                if (xc_last) y_reg <= y_reg + 1'b1;
            end
            B_MUL: begin
                sum_reg  <= sum_w;
                prod_reg <= prod_w;
            end
            B_ACC: begin
                acc_reg <= acc_reg + {{4{term_w[31]}}, term_w};
                if (!t_last) t_reg <= t_reg + 1'b1;
            end
            B_EMIT: begin
                if (out_free) begin
                    t_reg   <= '0;
                    acc_reg <= '0;
                    x_reg   <= x_last ? '0 : x_reg + 1'b1;
                    if (x_last) y_reg <= y_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (state_reg == B_STAT) begin
                code_reg     <= cmd_reg.code;
                row_reg      <= 3'd0;
                col_reg      <= 3'd0;
                value_reg    <= 32'sd0;
                rows_out_reg <= 4'd0;
                cols_out_reg <= 4'd0;
                last_reg     <= 1'b1;
            end else begin
                code_reg     <= CODE_ELEM;
                row_reg      <= 3'(y_reg);
                col_reg      <= 3'(x_reg);
                value_reg    <= res_w;
                rows_out_reg <= cmd_reg.nrows;
                cols_out_reg <= cmd_reg.ncols;
                last_reg     <= x_last && y_last;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_code      = code_reg;
    assign m_out_row   = row_reg;
    assign m_out_col   = col_reg;
    assign m_out_value = value_reg;
    assign m_rows_out  = rows_out_reg;
    assign m_cols_out  = cols_out_reg;
    assign m_last      = last_reg;

endmodule
